// ----- design/tmbcs_pkg.sv -----
// Shared types and constants for the two-mode bitmap cell scan-out block.
`default_nettype none
package tmbcs_pkg;
  localparam int CNT_W      = 5;
  localparam int PIX_W      = 4;
  localparam int PIX_N      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef logic [7:0]              byte_t;
  typedef logic [2:0]              color_t;
  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic [PIX_N*PIX_W-1:0]  pixel_row_t;
  typedef logic [CNT_W-1:0]        frame_cnt_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;

  localparam cfg_idx_t REG_HIRES_MODE = 1'd0;
  localparam cfg_idx_t REG_MONO_COLOR = 1'd1;

  localparam color_t COLOR_INVERT = 3'd7;
endpackage
`default_nettype wire

// ----- design/tmbcs_if.sv -----
// Channel interfaces: cell input, pixel row output and configuration write.
`default_nettype none
interface tmbcs_in_if;
  import tmbcs_pkg::*;
  logic  valid;
  logic  ready;
  byte_t first_byte;
  byte_t second_byte;
  logic  frame_end;
  modport source (output valid, output first_byte, output second_byte, output frame_end,
                  input ready);
  modport sink   (input valid, input first_byte, input second_byte, input frame_end,
                  output ready);
endinterface

interface tmbcs_out_if;
  import tmbcs_pkg::*;
  logic       valid;
  logic       ready;
  pixel_row_t pixel_row;
  logic       last_of_frame;
  modport source (output valid, output pixel_row, output last_of_frame, input ready);
  modport sink   (input valid, input pixel_row, input last_of_frame, output ready);
endinterface

interface tmbcs_cfg_if;
  import tmbcs_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/two_mode_bitmap_cell_scanout.sv -----
// Two-mode bitmap cell scan-out: one video cell in, one 16-pixel row out.
// Channels: in_ch carries a two-byte cell plus a frame_end flag; out_ch
// carries the 64-bit row of sixteen 4-bit palette indices and last_of_frame;
// cfg_ch writes hires_mode (index 0) and mono_color (index 1), always ready.
// Path: a transferred cell is held in the input register, then in the result
// register, which drives out_ch.
// Throughput: one cell per cycle unless out_ch stalls; the frame counter
// compare and the pixel select form the only logic between the two registers.
// Stall: when out_ch is not taken the result holds, the input register keeps
// one more cell, and in_ch.ready drops only once both are full.
// Reset: synchronous active-low rst_n empties both registers, clears the
// frame counter and sets hires_mode and mono_color to zero.
// Blink: a lores cell with attribute bit 7 swaps foreground and background
// while the frame counter equals BLINK_FRAME; each frame_end cell advances
// the counter, which returns to zero after the blink frame.
`default_nettype none
module two_mode_bitmap_cell_scanout #(
  parameter int BLINK_FRAME = 20
) (
  input  wire           clk,
  input  wire           rst_n,
  tmbcs_in_if.sink      in_ch,
  tmbcs_out_if.source   out_ch,
  tmbcs_cfg_if.sink     cfg_ch
);
  import tmbcs_pkg::*;

  localparam frame_cnt_t BlinkCnt = CNT_W'(BLINK_FRAME);

  logic       hires_r, hires_nxt;
  color_t     mono_r, mono_nxt;
  frame_cnt_t fcnt_r, fcnt_nxt;

  logic       s1_valid_r, s1_valid_nxt;
  byte_t      s1_first_r, s1_second_r;
  logic       s1_fend_r;

  logic       out_valid_r, out_valid_nxt;
  pixel_row_t out_row_r, row_nxt;
  logic       out_last_r;

  logic       out_free, in_xfer, advance, blink;
  logic [15:0] word;
  pix_t       fg, bg, pix_set, pix_clr;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign advance      = s1_valid_r && out_free;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_row     = out_row_r;
  assign out_ch.last_of_frame = out_last_r;

  always_comb begin
    hires_nxt = hires_r;
    mono_nxt  = mono_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_HIRES_MODE: hires_nxt = cfg_ch.data[0];
        REG_MONO_COLOR: mono_nxt  = cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    blink = s1_second_r[7] && (fcnt_r == BlinkCnt);
    fg    = {s1_second_r[6], s1_second_r[2:0]};
    bg    = {s1_second_r[6], s1_second_r[5:3]};
    if (blink) begin
      fg = {s1_second_r[6], s1_second_r[5:3]};
      bg = {s1_second_r[6], s1_second_r[2:0]};
    end
    if (hires_r) begin
      pix_set = {1'b0, mono_r ^ COLOR_INVERT};
      pix_clr = {1'b0, mono_r};
      word    = {s1_first_r, s1_second_r};
    end else begin
      pix_set = fg;
      pix_clr = bg;
      word    = {s1_first_r[7], s1_first_r[7], s1_first_r[6], s1_first_r[6],
                 s1_first_r[5], s1_first_r[5], s1_first_r[4], s1_first_r[4],
                 s1_first_r[3], s1_first_r[3], s1_first_r[2], s1_first_r[2],
                 s1_first_r[1], s1_first_r[1], s1_first_r[0], s1_first_r[0]};
    end
    for (int k = 0; k < PIX_N; k++) begin
      row_nxt[k*PIX_W +: PIX_W] = word[PIX_N-1-k] ? pix_set : pix_clr;
    end
  end

  always_comb begin
    fcnt_nxt = fcnt_r;
    if (advance && s1_fend_r) begin
      fcnt_nxt = (fcnt_r == BlinkCnt) ? '0 : fcnt_r + 1'b1;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hires_r     <= 1'b0;
      mono_r      <= '0;
      fcnt_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hires_r     <= hires_nxt;
      mono_r      <= mono_nxt;
      fcnt_r      <= fcnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_first_r  <= in_ch.first_byte;
      s1_second_r <= in_ch.second_byte;
      s1_fend_r   <= in_ch.frame_end;
    end
    if (advance) begin
      out_row_r  <= row_nxt;
      out_last_r <= s1_fend_r;
    end
  end
endmodule
`default_nettype wire

// ----- bench/tb_two_mode_bitmap_cell_scanout.sv -----
// Self-checking bench for the two-mode bitmap cell scan-out block under random flow control.
`timescale 1ns / 100ps
module tb_two_mode_bitmap_cell_scanout;
  import tmbcs_pkg::*;

  localparam int BLINK_FRAME = 20;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    byte_t first_byte;
    byte_t second_byte;
    logic  frame_end;
  } cell_t;

  typedef struct {
    pixel_row_t row;
    logic       last_of_frame;
  } row_t;

  logic clk;
  logic rst_n;

  tmbcs_in_if  in_ch();
  tmbcs_out_if out_ch();
  tmbcs_cfg_if cfg_ch();

  two_mode_bitmap_cell_scanout #(.BLINK_FRAME(BLINK_FRAME)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cell_t      cells_pending[$];
  row_t       rows_expected[$];
  logic       mode_hires  = 1'b0;
  color_t     clear_color = '0;
  frame_cnt_t blink_cnt   = '0;
  int         mismatch_cnt = 0;
  int         tx_mode = 1;
  int         rx_mode = 1;
  int         hold_req = 0;
  int         hold_seen;
  int         hold_left;
  int         gap_left;
  int         burst_left;
  int         rx_run;
  int         rx_stall;
  int         frame_left = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.first_byte  = '0;
    in_ch.second_byte = '0;
    in_ch.frame_end   = 1'b0;
    out_ch.ready      = 1'b0;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  task automatic report(string msg);
    $display("ERROR: %s", msg);
    mismatch_cnt++;
  endtask

  function automatic pixel_row_t scan_cell(byte_t pat, byte_t attr);
    pixel_row_t   row;
    pix_t         fg;
    pix_t         bg;
    pix_t         tmp;
    pix_t         px;
    color_t       set_color;
    logic [15:0]  word;
    row = '0;
    if (mode_hires) begin
      word = {pat, attr};
      set_color = clear_color ^ COLOR_INVERT;
      for (int k = 0; k < 16; k++) begin
        px = word[15-k] ? {1'b0, set_color} : {1'b0, clear_color};
        row[4*k +: 4] = px;
      end
    end else begin
      fg = {attr[6], attr[2:0]};
      bg = {attr[6], attr[5:3]};
      if (attr[7] && blink_cnt == BLINK_FRAME) begin
        tmp = fg;
        fg = bg;
        bg = tmp;
      end
      for (int k = 0; k < 8; k++) begin
        px = pat[7-k] ? fg : bg;
        row[8*k +: 8] = {px, px};
      end
    end
    return row;
  endfunction

  function automatic byte_t pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return byte_t'($urandom);
    endcase
  endfunction

  task automatic push_cell(byte_t b0, byte_t b1, logic fe);
    cell_t c;
    c.first_byte  = b0;
    c.second_byte = b1;
    c.frame_end   = fe;
    cells_pending.push_back(c);
  endtask

  task automatic push_random_cell();
    logic fe;
    if (frame_left == 0) begin
      fe = 1'b1;
      frame_left = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
    end else begin
      fe = 1'b0;
      frame_left--;
    end
    push_cell(pick_byte(), pick_byte(), fe);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_HIRES_MODE) mode_hires = val[0];
    else clear_color = val[2:0];
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk); while (cells_pending.size() != 0 || in_ch.valid ||
                              rows_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // cell driver
  always @(posedge clk) begin
    cell_t c;
    row_t  r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        r.row = scan_cell(in_ch.first_byte, in_ch.second_byte);
        r.last_of_frame = in_ch.frame_end;
        rows_expected.push_back(r);
        if (in_ch.frame_end) blink_cnt = (blink_cnt == BLINK_FRAME) ? '0 : blink_cnt + 1'b1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (cells_pending.size() > 0) begin
          c = cells_pending.pop_front();
          in_ch.first_byte  <= c.first_byte;
          in_ch.second_byte <= c.second_byte;
          in_ch.frame_end   <= c.frame_end;
          in_ch.valid       <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            if (tx_mode == 0 || $urandom_range(0, 3) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, (tx_mode == 1) ? 3 : 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // row monitor
  always @(posedge clk) begin
    row_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_run = 0;
      rx_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (rows_expected.size() == 0) begin
          report($sformatf("row %h with no cell outstanding", out_ch.pixel_row));
        end else begin
          want = rows_expected.pop_front();
          if (out_ch.pixel_row !== want.row)
            report($sformatf("pixel_row %h, want %h", out_ch.pixel_row, want.row));
          if (out_ch.last_of_frame !== want.last_of_frame)
            report($sformatf("last_of_frame %b, want %b", out_ch.last_of_frame,
                             want.last_of_frame));
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (rx_run > 0) begin
        rx_run--;
        out_ch.ready <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        rx_run = $urandom_range(0, 12);
        rx_stall = (rx_mode == 0) ? 0 : $urandom_range(1, (rx_mode == 1) ? 2 : 6);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    bit        hires;
    color_t    mono;
    cfg_data_t hires_val;
    cfg_data_t mono_val;
    rst_n        = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // lores, reset settings
    push_cell(8'h00, 8'h00, 1'b1);
    push_cell(8'hFF, 8'h00, 1'b1);
    push_cell(8'hFF, 8'hFF, 1'b1);
    push_cell(8'h00, 8'hFF, 1'b1);
    push_cell(8'hAA, 8'h07, 1'b1);
    push_cell(8'h55, 8'h38, 1'b1);
    push_cell(8'hA5, 8'h47, 1'b1);
    push_cell(8'h5A, 8'h78, 1'b1);
    push_cell(8'h81, 8'hC1, 1'b1);
    push_cell(8'h7E, 8'h3F, 1'b1);
    drain();

    write_reg(REG_HIRES_MODE, 8'h01);
    write_reg(REG_MONO_COLOR, 8'h07);
    @(negedge clk);
    push_cell(8'h00, 8'h00, 1'b1);
    push_cell(8'hFF, 8'hFF, 1'b1);
    push_cell(8'h80, 8'h01, 1'b1);
    push_cell(8'hAA, 8'hAA, 1'b1);
    push_cell(8'h55, 8'h55, 1'b1);
    drain();

    write_reg(REG_HIRES_MODE, 8'hFF);
    write_reg(REG_MONO_COLOR, 8'hF8);
    @(negedge clk);
    push_cell(8'h01, 8'h80, 1'b1);
    push_cell(8'hFF, 8'h00, 1'b1);
    push_cell(8'h00, 8'hFF, 1'b1);
    push_cell(8'hC3, 8'h3C, 1'b1);
    push_cell(8'h12, 8'h34, 1'b1);
    // hires at the blink frame: no swap
    push_cell(8'hFF, 8'hFF, 1'b0);
    drain();

    // lores at the blink frame, then past the wrap
    write_reg(REG_HIRES_MODE, 8'hFE);
    @(negedge clk);
    push_cell(8'hA5, 8'hC5, 1'b0);
    push_cell(8'hA5, 8'h4D, 1'b0);
    push_cell(8'hFF, 8'h80, 1'b1);
    push_cell(8'h3C, 8'hBF, 1'b0);
    drain();

    for (int p = 0; p < 8; p++) begin
      hires = p[0];
      mono = (p == 1) ? 3'd7 : (p == 3) ? 3'd0 : color_t'($urandom_range(0, 7));
      hires_val = {7'($urandom), hires};
      mono_val = {5'($urandom), mono};
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_HIRES_MODE, hires_val);
        write_reg(REG_MONO_COLOR, mono_val);
      end else begin
        write_reg(REG_MONO_COLOR, mono_val);
        write_reg(REG_HIRES_MODE, hires_val);
      end
      @(negedge clk);
      tx_mode = p % 3;
      rx_mode = (p / 2) % 3;
      if (p == 2 || p == 5) hold_req++;
      repeat (66) push_random_cell();
      drain();
    end

    if (rows_expected.size() != 0)
      report($sformatf("%0d rows never arrived", rows_expected.size()));
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/tmbcs_pkg.sv
design/tmbcs_if.sv
design/two_mode_bitmap_cell_scanout.sv
bench/tb_two_mode_bitmap_cell_scanout.sv
